>>> rtl/shake_oscillator_bank_mixer_core_macros.svh
// Assertion macros shared by the checker of the shake mixer core.
// Every macro samples on clk and is disabled while rst_n is low.
`ifndef SHAKE_OSCILLATOR_BANK_MIXER_CORE_MACROS_SVH
`define SHAKE_OSCILLATOR_BANK_MIXER_CORE_MACROS_SVH

// Same-cycle implication.
`define SOBM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define SOBM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/sobm_pkg.sv
// Shared types, constants and the sine table function of the shake mixer.
// No dependencies; the cell, evaluation, top-level and checker files import it.
`timescale 1ns / 1ps
package sobm_pkg;

  localparam int unsigned MAX_SHAKES_DEF = 8;
  localparam int unsigned SINE_DEPTH_DEF = 256;

  // Request modes.
  localparam logic [1:0] MODE_STAGE   = 2'd0;
  localparam logic [1:0] MODE_TRIGGER = 2'd1;
  localparam logic [1:0] MODE_TICK    = 2'd2;
  localparam logic [1:0] MODE_CLEAR   = 2'd3;

  localparam logic [31:0] INV_TWO_PI_Q32 = 32'd683565276;
  localparam logic [63:0] HALF_PI_Q30    = 64'd1686629713;
  localparam logic [16:0] ENV_ONE        = 17'd65536;
  localparam int unsigned ACC_W          = 22;

  // One shake held by a cell of the chain.
  typedef struct packed {
    logic            valid;
    logic [23:0]     elapsed;
    logic [23:0]     duration;
    logic [23:0]     fade_in;
    logic [23:0]     fade_out;
    logic [3:0][15:0] amp;
    logic [3:0][15:0] freq;
  } slot_t;

  // Command broadcast to every cell.
  typedef enum logic [2:0] {
    OP_HOLD    = 3'd0,
    OP_SHIFT   = 3'd1,
    OP_COMPACT = 3'd2,
    OP_WRITE   = 3'd3,
    OP_CLEAR   = 3'd4
  } cell_op_t;

  // Result of the evaluation unit: one axis contribution and end of shake.
  typedef struct packed {
    logic               done;
    logic               valid;
    logic [1:0]         axis;
    logic signed [17:0] value;
  } eval_out_t;

  // Sine entry k of a table of depth entries over one turn, signed Q1.15.
  // Evaluated at elaboration only.
  function automatic logic signed [15:0] sine_entry(input int unsigned k,
                                                    input int unsigned depth);
    logic [63:0] num;
    logic [63:0] rr;
    logic [63:0] t;
    logic [63:0] u;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [1:0]  q;
    longint      s;
    longint      r;
    num = 64'(k) << 32;
    rr  = 64'd0;
    t   = 64'd0;
    for (int b = 63; b >= 0; b--) begin
      rr = {rr[62:0], num[b]};
      if (rr >= 64'(depth)) begin
        rr   = rr - 64'(depth);
        t[b] = 1'b1;
      end
    end
    q = t[31:30];
    u = {34'd0, t[29:0]};
    if (q[0]) begin
      u = 64'h4000_0000 - u;
    end
    x    = (u * HALF_PI_Q30) >> 30;
    x2   = (x * x) >> 30;
    s    = longint'(x);
    term = ((x * x2) >> 30) / 64'd6;
    s    = s - longint'(term);
    term = ((term * x2) >> 30) / 64'd20;
    s    = s + longint'(term);
    term = ((term * x2) >> 30) / 64'd42;
    s    = s - longint'(term);
    term = ((term * x2) >> 30) / 64'd72;
    s    = s + longint'(term);
    if (s < 0) begin
      s = 0;
    end
    r = (s + 16384) >>> 15;
    if (r > 32767) begin
      r = 32767;
    end
    return q[1] ? -16'(r) : 16'(r);
  endfunction

endpackage

>>> rtl/sobm_cell.sv
// One cell of the shake chain: holds one shake and takes its neighbor's.
// Depends on sobm_pkg.
`timescale 1ns / 1ps
module sobm_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  sobm_pkg::cell_op_t op,
  input  logic              hole_in,
  input  sobm_pkg::slot_t   nbr,
  input  sobm_pkg::slot_t   wr,
  output sobm_pkg::slot_t   q,
  output logic              hole_out
);
  import sobm_pkg::*;

  logic  valid_r;
  logic  valid_nxt;
  slot_t data_r;
  logic  take_nbr;
  logic  take_wr;

  // A compaction pulls from the right once a hole exists at or before here;
  // a write lands in the first empty cell.
  always_comb begin
    take_nbr  = 1'b0;
    take_wr   = 1'b0;
    valid_nxt = valid_r;
    unique case (op)
      OP_SHIFT: begin
        take_nbr = 1'b1;
      end
      OP_COMPACT: begin
        take_nbr = hole_in | ~valid_r;
      end
      OP_WRITE: begin
        take_wr = ~valid_r & ~hole_in;
      end
      OP_CLEAR: begin
        valid_nxt = 1'b0;
      end
      default: begin
      end
    endcase
    if (take_nbr) begin
      valid_nxt = nbr.valid;
    end else if (take_wr) begin
      valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take_nbr) begin
      data_r <= nbr;
    end else if (take_wr) begin
      data_r <= wr;
    end
  end

  always_comb begin
    q        = data_r;
    q.valid  = valid_r;
    hole_out = hole_in | ~valid_r;
  end

endmodule

>>> rtl/sobm_div.sv
// Restoring divider, one quotient bit per cycle, for the envelope ratios.
// The quotient must fit 17 bits. Uses nothing from sobm_pkg.
`timescale 1ns / 1ps
module sobm_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [40:0] num,
  input  logic [23:0] den,
  output logic        done,
  output logic [16:0] quot
);
  logic [23:0] rem_r;
  logic [16:0] sh_r;
  logic [23:0] den_r;
  logic [4:0]  cnt_r;
  logic        run_r;
  logic        done_r;
  logic [24:0] trial;
  logic        fits;

  assign trial = {rem_r, sh_r[16]};
  assign fits  = trial >= {1'b0, den_r};

  // Control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 5'd0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= 5'd17;
      end else if (run_r) begin
        cnt_r <= cnt_r - 5'd1;
        if (cnt_r == 5'd1) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath: the numerator shifts out as the quotient shifts in.
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= num[40:17];
      sh_r  <= num[16:0];
      den_r <= den;
    end else if (run_r) begin
      rem_r <= fits ? 24'(trial - {1'b0, den_r}) : trial[23:0];
      sh_r  <= {sh_r[15:0], fits};
    end
  end

  assign done = done_r;
  assign quot = sh_r;

endmodule

>>> rtl/sobm_eval.sv
// Evaluation unit: envelope of one shake, then its four sine oscillators,
// one axis at a time. Depends on sobm_pkg and sobm_div.
`timescale 1ns / 1ps
module sobm_eval #(
  parameter int unsigned SINE_TABLE_DEPTH = sobm_pkg::SINE_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  sobm_pkg::slot_t     slot,
  input  logic [23:0]         elapsed,
  output sobm_pkg::eval_out_t res
);
  import sobm_pkg::*;

  localparam int unsigned IDX_W = (SINE_TABLE_DEPTH > 1) ? $clog2(SINE_TABLE_DEPTH) : 1;
  localparam int unsigned DEP_W = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int unsigned FM_W  = 24 + DEP_W;

  typedef enum logic [11:0] {
    E_IDLE  = 12'h001,
    E_FIN   = 12'h002,
    E_FINW  = 12'h004,
    E_FOUT  = 12'h008,
    E_FOUTW = 12'h010,
    E_PH    = 12'h020,
    E_LO    = 12'h040,
    E_HI    = 12'h080,
    E_FRAC  = 12'h100,
    E_SIN   = 12'h200,
    E_AS    = 12'h400,
    E_ENV   = 12'h800
  } ev_state_t;

  ev_state_t          st_r;
  ev_state_t          st_nxt;
  logic [16:0]        env_r;
  logic [1:0]         axis_r;
  logic [39:0]        p_r;
  logic [51:0]        pl_r;
  logic [51:0]        ph_r;
  logic [23:0]        frac_r;
  logic signed [15:0] sin_r;
  logic signed [31:0] as_r;
  logic               done_r;
  logic               valid_r;
  logic [1:0]         axis_out_r;
  logic signed [17:0] value_r;

  logic signed [15:0] sine_tab [SINE_TABLE_DEPTH];
  logic [23:0]        rem;
  logic               fin_on;
  logic               fout_on;
  logic               div_start;
  logic [40:0]        div_num;
  logic [23:0]        div_den;
  logic               div_done;
  logic [16:0]        div_q;
  logic [55:0]        frac_sum;
  logic [FM_W-1:0]    fm;
  logic [IDX_W-1:0]   idx;
  logic signed [49:0] v;
  logic signed [49:0] vr;

  // Sine table as constant logic.
  for (genvar k = 0; k < SINE_TABLE_DEPTH; k++) begin : g_tab
    assign sine_tab[k] = sine_entry(k, SINE_TABLE_DEPTH);
  end

  // Envelope ratio requests to the divider.
  always_comb begin
    rem       = slot.duration - elapsed;
    fin_on    = (slot.fade_in != 24'd0) && (elapsed < slot.fade_in);
    fout_on   = (slot.fade_out != 24'd0) && (rem < slot.fade_out);
    div_start = ((st_r == E_FIN) && fin_on) || ((st_r == E_FOUT) && fout_on);
    div_num   = (st_r == E_FIN) ? {1'b0, elapsed, 16'd0} : 41'(env_r) * 41'(rem);
    div_den   = (st_r == E_FIN) ? slot.fade_in : slot.fade_out;
  end

  sobm_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_q)
  );

  // Phase fraction, table index and rounded contribution.
  always_comb begin
    frac_sum = {4'd0, pl_r} + {ph_r[35:0], 20'd0};
    fm       = FM_W'(frac_r) * FM_W'(SINE_TABLE_DEPTH);
    idx      = fm[24 +: IDX_W];
    v        = as_r * $signed({1'b0, env_r});
    vr       = v + 50'sd1073741824;
  end

  // Sequencer.
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      E_IDLE:  st_nxt = start ? E_FIN : E_IDLE;
      E_FIN:   st_nxt = fin_on ? E_FINW : E_FOUT;
      E_FINW:  st_nxt = div_done ? E_FOUT : E_FINW;
      E_FOUT:  st_nxt = fout_on ? E_FOUTW : E_PH;
      E_FOUTW: st_nxt = div_done ? E_PH : E_FOUTW;
      E_PH:    st_nxt = E_LO;
      E_LO:    st_nxt = E_HI;
      E_HI:    st_nxt = E_FRAC;
      E_FRAC:  st_nxt = E_SIN;
      E_SIN:   st_nxt = E_AS;
      E_AS:    st_nxt = E_ENV;
      E_ENV:   st_nxt = (axis_r == 2'd3) ? E_IDLE : E_PH;
      default: st_nxt = E_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= E_IDLE;
      done_r  <= 1'b0;
      valid_r <= 1'b0;
      axis_r  <= 2'd0;
    end else begin
      st_r    <= st_nxt;
      done_r  <= (st_r == E_ENV) && (axis_r == 2'd3);
      valid_r <= (st_r == E_ENV);
      if (st_r == E_IDLE) begin
        axis_r <= 2'd0;
      end else if (st_r == E_ENV) begin
        axis_r <= axis_r + 2'd1;
      end
    end
  end

  // Datapath registers, at most one multiplier per stage.
  always_ff @(posedge clk) begin
    if (st_r == E_IDLE) begin
      env_r <= ENV_ONE;
    end else if (((st_r == E_FINW) || (st_r == E_FOUTW)) && div_done) begin
      env_r <= div_q;
    end
    if (st_r == E_PH) begin
      p_r <= 40'(slot.freq[axis_r]) * 40'(elapsed);
    end
    if (st_r == E_LO) begin
      pl_r <= 52'(p_r[19:0]) * 52'(INV_TWO_PI_Q32);
    end
    if (st_r == E_HI) begin
      ph_r <= 52'(p_r[39:20]) * 52'(INV_TWO_PI_Q32);
    end
    if (st_r == E_FRAC) begin
      frac_r <= frac_sum[55:32];
    end
    if (st_r == E_SIN) begin
      sin_r <= sine_tab[idx];
    end
    if (st_r == E_AS) begin
      as_r <= $signed(slot.amp[axis_r]) * sin_r;
    end
    if (st_r == E_ENV) begin
      value_r    <= vr[48:31];
      axis_out_r <= axis_r;
    end
  end

  always_comb begin
    res.done  = done_r;
    res.valid = valid_r;
    res.axis  = axis_out_r;
    res.value = value_r;
  end

endmodule

>>> rtl/shake_oscillator_bank_mixer_core.sv
// Top level of the camera shake mixer: chain of shake cells and sequencer.
// Depends on sobm_pkg, sobm_cell and sobm_eval.
//
// Stage, trigger and clear requests never raise busy, so they can be
// issued back to back. A tick request raises busy and walks the chain: the
// head cell is examined once per shake slot (MAX_SHAKES steps), and each
// live shake is evaluated there: two optional envelope divides, the work
// of each of the four axes and a handover. A compaction pass then closes
// the gaps left by expired shakes. The result appears on the out_ ports for
// exactly one cycle with out_valid high, in the cycle busy falls; the
// receiver cannot stall it, so it must take the result in that cycle.
`timescale 1ns / 1ps
module shake_oscillator_bank_mixer_core #(
  parameter int unsigned MAX_SHAKES       = sobm_pkg::MAX_SHAKES_DEF,
  parameter int unsigned SINE_TABLE_DEPTH = sobm_pkg::SINE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_mode,
  input  logic [1:0]         in_axis,
  input  logic signed [15:0] in_amplitude,
  input  logic [15:0]        in_frequency,
  input  logic [23:0]        in_duration,
  input  logic [23:0]        in_blend_in,
  input  logic [23:0]        in_blend_out,
  input  logic [23:0]        in_time_seconds,
  output logic               out_valid,
  output logic signed [18:0] out_forward_offset,
  output logic signed [18:0] out_right_offset,
  output logic signed [18:0] out_up_offset,
  output logic signed [18:0] out_fov_delta,
  output logic               out_any_active
);
  import sobm_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_SHAKES + 1);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_HEAD = 4'b0010,
    ST_EVAL = 4'b0100,
    ST_PACK = 4'b1000
  } top_state_t;

  top_state_t              st_r;
  logic [CNT_W-1:0]        step_r;
  logic [CNT_W-1:0]        pack_r;
  logic [23:0]             tsec_r;
  logic signed [ACC_W-1:0] acc_r [4];
  logic                    active_r;
  logic [3:0][15:0]        staged_amp_r;
  logic [3:0][15:0]        staged_freq_r;
  logic                    out_valid_r;
  logic signed [18:0]      out_off_r [4];

  slot_t     cell_q [MAX_SHAKES];
  logic      hole [MAX_SHAKES];
  cell_op_t  cell_op;
  slot_t     tail_in;
  slot_t     new_slot;
  slot_t     head;
  slot_t     rot_slot;
  logic      accept;
  logic      trig_ok;
  logic      full;
  logic [24:0] e_sum;
  logic [23:0] head_e;
  logic      head_live;
  logic      steps_done;
  logic      ev_start;
  eval_out_t ev;

  function automatic logic signed [18:0] sat19(input logic signed [ACC_W-1:0] a);
    if (a > ACC_W'(262143)) begin
      return 19'sd262143;
    end else if (a < -ACC_W'(262144)) begin
      return -19'sd262144;
    end
    return a[18:0];
  endfunction

  assign busy   = (st_r != ST_IDLE);
  assign accept = start && !busy;

  // Head of the chain and its advanced elapsed time, saturating.
  always_comb begin
    head       = cell_q[0];
    e_sum      = {1'b0, head.elapsed} + {1'b0, tsec_r};
    head_e     = e_sum[24] ? 24'hFF_FFFF : e_sum[23:0];
    head_live  = head.valid && (head_e < head.duration);
    rot_slot         = head;
    rot_slot.elapsed = head_e;
    steps_done = (step_r == CNT_W'(MAX_SHAKES));
    ev_start   = (st_r == ST_HEAD) && !steps_done && head_live;
  end

  // New shake built from the request and the staged oscillators.
  always_comb begin
    new_slot.valid    = 1'b1;
    new_slot.elapsed  = in_time_seconds;
    new_slot.duration = in_duration;
    new_slot.fade_in  = in_blend_in;
    new_slot.fade_out = in_blend_out;
    new_slot.amp      = staged_amp_r;
    new_slot.freq     = staged_freq_r;
    trig_ok = (in_duration != 24'd0) && (in_time_seconds < in_duration);
    full    = cell_q[MAX_SHAKES-1].valid;
  end

  // Chain command for this cycle.
  always_comb begin
    cell_op       = OP_HOLD;
    tail_in       = rot_slot;
    tail_in.valid = 1'b0;
    unique case (st_r)
      ST_IDLE: begin
        if (accept && (in_mode == MODE_TRIGGER) && trig_ok) begin
          if (full) begin
            cell_op = OP_SHIFT;
            tail_in = new_slot;
          end else begin
            cell_op = OP_WRITE;
          end
        end else if (accept && (in_mode == MODE_CLEAR)) begin
          cell_op = OP_CLEAR;
        end
      end
      ST_HEAD: begin
        if (!steps_done && !head_live) begin
          cell_op = OP_SHIFT;
        end
      end
      ST_EVAL: begin
        if (ev.done) begin
          cell_op       = OP_SHIFT;
          tail_in.valid = 1'b1;
        end
      end
      ST_PACK: begin
        cell_op = OP_COMPACT;
      end
      default: begin
      end
    endcase
  end

  // The chain of shake cells; the tail takes tail_in.
  for (genvar i = 0; i < MAX_SHAKES; i++) begin : g_cell
    sobm_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .op       (cell_op),
      .hole_in  ((i == 0) ? 1'b0 : hole[(i == 0) ? 0 : i-1]),
      .nbr      ((i == MAX_SHAKES-1) ? tail_in : cell_q[(i == MAX_SHAKES-1) ? i : i+1]),
      .wr       (new_slot),
      .q        (cell_q[i]),
      .hole_out (hole[i])
    );
  end

  sobm_eval #(
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
  ) u_eval (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (ev_start),
    .slot    (head),
    .elapsed (head_e),
    .res     (ev)
  );

  // Sequencer and counters.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      step_r      <= '0;
      pack_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (st_r)
        ST_IDLE: begin
          if (accept && (in_mode == MODE_TICK)) begin
            st_r   <= ST_HEAD;
            step_r <= '0;
          end
        end
        ST_HEAD: begin
          if (steps_done) begin
            st_r   <= ST_PACK;
            pack_r <= '0;
          end else if (head_live) begin
            st_r <= ST_EVAL;
          end else begin
            step_r <= step_r + CNT_W'(1);
          end
        end
        ST_EVAL: begin
          if (ev.done) begin
            st_r   <= ST_HEAD;
            step_r <= step_r + CNT_W'(1);
          end
        end
        ST_PACK: begin
          pack_r <= pack_r + CNT_W'(1);
          if (pack_r == CNT_W'(MAX_SHAKES - 1)) begin
            st_r        <= ST_IDLE;
            out_valid_r <= 1'b1;
          end
        end
        default: begin
          st_r <= ST_IDLE;
        end
      endcase
    end
  end

  // Staged oscillators.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      staged_amp_r  <= '0;
      staged_freq_r <= '0;
    end else if (accept && (in_mode == MODE_STAGE)) begin
      staged_amp_r[in_axis]  <= in_amplitude;
      staged_freq_r[in_axis] <= in_frequency;
    end
  end

  // Per-axis sums and the activity flag.
  always_ff @(posedge clk) begin
    if (accept && (in_mode == MODE_TICK)) begin
      tsec_r   <= in_time_seconds;
      active_r <= 1'b0;
      for (int a = 0; a < 4; a++) begin
        acc_r[a] <= '0;
      end
    end else begin
      if (ev.valid) begin
        acc_r[ev.axis] <= acc_r[ev.axis] + ACC_W'(ev.value);
      end
      if (ev.done) begin
        active_r <= 1'b1;
      end
    end
    if ((st_r == ST_PACK) && (pack_r == CNT_W'(MAX_SHAKES - 1))) begin
      for (int a = 0; a < 4; a++) begin
        out_off_r[a] <= sat19(acc_r[a]);
      end
      out_any_active <= active_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_forward_offset = out_off_r[0];
  assign out_right_offset   = out_off_r[1];
  assign out_up_offset      = out_off_r[2];
  assign out_fov_delta      = out_off_r[3];

endmodule

>>> rtl/sobm_chk.sv
// Port-level checker for the shake mixer core, bound to the top level.
// Depends on sobm_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "shake_oscillator_bank_mixer_core_macros.svh"
module sobm_chk (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic [1:0]         in_mode,
  input logic               out_valid,
  input logic signed [18:0] out_forward_offset,
  input logic signed [18:0] out_right_offset,
  input logic signed [18:0] out_up_offset,
  input logic signed [18:0] out_fov_delta,
  input logic               out_any_active
);
  import sobm_pkg::*;

  // A result comes only once the tick has finished.
  `SOBM_ASSERT_IMP(a_out_when_idle, out_valid, !busy, "result shown while busy")
  // A result lasts one cycle.
  `SOBM_ASSERT_NXT(a_out_single, out_valid, !out_valid, "result held more than one cycle")
  // A tick request starts the walk of the chain.
  `SOBM_ASSERT_NXT(a_tick_busy, start && !busy && in_mode == MODE_TICK, busy, "tick did not start")
  // Other requests complete at once.
  `SOBM_ASSERT_NXT(a_quick_req, start && !busy && in_mode != MODE_TICK, !busy, "request stalled")
  // No contribution means all sums are zero.
  `SOBM_ASSERT_IMP(a_idle_zero, out_valid && !out_any_active, out_forward_offset == 0 && out_right_offset == 0 && out_up_offset == 0 && out_fov_delta == 0, "nonzero sum with no active shake")

endmodule

bind shake_oscillator_bank_mixer_core sobm_chk u_sobm_chk (
  .clk                (clk),
  .rst_n              (rst_n),
  .start              (start),
  .busy               (busy),
  .in_mode            (in_mode),
  .out_valid          (out_valid),
  .out_forward_offset (out_forward_offset),
  .out_right_offset   (out_right_offset),
  .out_up_offset      (out_up_offset),
  .out_fov_delta      (out_fov_delta),
  .out_any_active     (out_any_active)
);
